### sv/hitr_pkg.sv
// hitr_pkg: shared types and constants of the hue/intensity to RGB pipeline.
// No dependencies; every other file of the block refers to it by scoped names.
package hitr_pkg;

   // Intensity is signed Q2.8 on the port and clamped to 0..2.0 inside
   localparam int INT_W  = 11;
   localparam int LVL_W  = 10;
   localparam int T_W    = LVL_W - 1;
   localparam int BYTE_W = 8;
   localparam int PACK_W = 3 * BYTE_W;

   localparam logic [LVL_W-1:0] LVL_ONE = 10'd256;
   localparam logic [LVL_W-1:0] LVL_MAX = 10'd512;

   // Sixths of the colour wheel, named by the colours at their two ends
   typedef enum logic [2:0] {
      SEC_RED_YELLOW    = 3'd0,
      SEC_YELLOW_GREEN  = 3'd1,
      SEC_GREEN_CYAN    = 3'd2,
      SEC_CYAN_BLUE     = 3'd3,
      SEC_BLUE_MAGENTA  = 3'd4,
      SEC_MAGENTA_RED   = 3'd5
   } sector_type;

endpackage

### sv/hitr_req_if.sv
// hitr_req_if: request channel carrying one hue and intensity beat.
// Depends on hitr_pkg for the intensity width.
interface hitr_req_if #(parameter int HUE_BITS = 16);
   logic                               valid;
   logic                               ready;
   logic        [HUE_BITS-1:0]         hue;
   logic signed [hitr_pkg::INT_W-1:0]  intensity;

   modport source (output valid, output hue, output intensity, input ready);
   modport sink   (input valid, input hue, input intensity, output ready);
endinterface

### sv/hitr_rsp_if.sv
// hitr_rsp_if: response channel carrying the colour bytes and packed word.
// Depends on hitr_pkg for the byte and packed widths.
interface hitr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hitr_pkg::BYTE_W-1:0]   red;
   logic [hitr_pkg::BYTE_W-1:0]   green;
   logic [hitr_pkg::BYTE_W-1:0]   blue;
   logic [hitr_pkg::PACK_W-1:0]   packed_color;

   modport source (output valid, output red, output green, output blue,
                   output packed_color, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input packed_color, output ready);
endinterface

### sv/hitr_sector.sv
// hitr_sector: first pipeline stage; splits the hue into sector and offset
// and clamps the intensity. Depends on hitr_pkg.
module hitr_sector #(
   parameter int HUE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic        [HUE_BITS-1:0]        in_hue,
   input  logic signed [hitr_pkg::INT_W-1:0] in_intensity,
   output logic                              out_valid,
   input  logic                              out_ready,
   output hitr_pkg::sector_type              out_sector,
   output logic        [HUE_BITS-1:0]        out_offset,
   output logic        [hitr_pkg::LVL_W-1:0] out_level
);
   localparam int SIX_W = HUE_BITS + 3;

   logic [SIX_W-1:0]           six;
   logic [hitr_pkg::LVL_W-1:0] level;

   logic                       v_ff, v_in;
   hitr_pkg::sector_type       sec_ff, sec_in;
   logic [HUE_BITS-1:0]        off_ff, off_in;
   logic [hitr_pkg::LVL_W-1:0] lvl_ff, lvl_in;

   // Six times the hue as shift and add: top bits are the sector
   assign six = ({3'b000, in_hue} << 2) + ({3'b000, in_hue} << 1);

   // Clamp the intensity to 0..2.0
   always_comb begin
      if (in_intensity[hitr_pkg::INT_W-1]) begin
         level = '0;
      end else if (in_intensity[hitr_pkg::LVL_W-1:0] > hitr_pkg::LVL_MAX) begin
         level = hitr_pkg::LVL_MAX;
      end else begin
         level = in_intensity[hitr_pkg::LVL_W-1:0];
      end
   end

   // Take a new beat whenever this stage is empty or drains this cycle
   assign in_ready = !v_ff || out_ready;

   always_comb begin
      v_in   = v_ff;
      sec_in = sec_ff;
      off_in = off_ff;
      lvl_in = lvl_ff;
      if (in_ready) begin
         v_in   = in_valid;
         sec_in = hitr_pkg::sector_type'(six[SIX_W-1:HUE_BITS]);
         off_in = six[HUE_BITS-1:0];
         lvl_in = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      sec_ff <= sec_in;
      off_ff <= off_in;
      lvl_ff <= lvl_in;
   end

   assign out_valid  = v_ff;
   assign out_sector = sec_ff;
   assign out_offset = off_ff;
   assign out_level  = lvl_ff;

   // Six times a fraction below one never reaches sector six
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      v_ff |-> (sec_ff <= hitr_pkg::SEC_MAGENTA_RED && lvl_ff <= hitr_pkg::LVL_MAX))
      else $error("stage one holds a sector or level out of range");

endmodule

### sv/hitr_scale.sv
// hitr_scale: second pipeline stage; picks the channel ramps of the sector
// and scales or blends them by the intensity. Depends on hitr_pkg.
module hitr_scale #(
   parameter int HUE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  hitr_pkg::sector_type              in_sector,
   input  logic [HUE_BITS-1:0]               in_offset,
   input  logic [hitr_pkg::LVL_W-1:0]        in_level,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [HUE_BITS+8:0]               out_num_r,
   output logic [HUE_BITS+8:0]               out_num_g,
   output logic [HUE_BITS+8:0]               out_num_b
);
   localparam int C_W    = HUE_BITS + 1;
   localparam int NUM_W  = HUE_BITS + 9;
   localparam int PROD_W = C_W + hitr_pkg::LVL_W;
   localparam logic [C_W-1:0]   ONE  = {1'b1, {HUE_BITS{1'b0}}};
   localparam logic [NUM_W-1:0] FULL = {1'b1, {(NUM_W-1){1'b0}}};

   logic [C_W-1:0]             ramp_up, ramp_dn;
   logic [C_W-1:0]             cr, cg, cb;
   logic                       blend;
   logic [hitr_pkg::T_W-1:0]   t;
   logic [hitr_pkg::LVL_W-1:0] mult_b;
   logic [hitr_pkg::LVL_W-1:0] t_full;

   logic                       v_ff, v_in;
   logic [NUM_W-1:0]           nr_ff, nr_in, ng_ff, ng_in, nb_ff, nb_in;

   // Scale c by the level, or blend toward white: c*256 + (1-c)*t
   function automatic logic [NUM_W-1:0] scale_chan(
      input logic [C_W-1:0]             c,
      input logic                       mix,
      input logic [hitr_pkg::LVL_W-1:0] b
   );
      logic [C_W-1:0]    a;
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] base;
      logic [PROD_W-1:0] sum;
      a    = mix ? (ONE - c) : c;
      prod = {{hitr_pkg::LVL_W{1'b0}}, a} * {{C_W{1'b0}}, b};
      base = mix ? ({{hitr_pkg::LVL_W{1'b0}}, c} << 8) : '0;
      sum  = prod + base;
      return sum[NUM_W-1:0];
   endfunction

   assign ramp_up = {1'b0, in_offset};
   assign ramp_dn = ONE - {1'b0, in_offset};

   // Channel ramps per sector
   always_comb begin
      case (in_sector)
         hitr_pkg::SEC_RED_YELLOW: begin
            cr = ONE;     cg = ramp_up; cb = '0;
         end
         hitr_pkg::SEC_YELLOW_GREEN: begin
            cr = ramp_dn; cg = ONE;     cb = '0;
         end
         hitr_pkg::SEC_GREEN_CYAN: begin
            cr = '0;      cg = ONE;     cb = ramp_up;
         end
         hitr_pkg::SEC_CYAN_BLUE: begin
            cr = '0;      cg = ramp_dn; cb = ONE;
         end
         hitr_pkg::SEC_BLUE_MAGENTA: begin
            cr = ramp_up; cg = '0;      cb = ONE;
         end
         default: begin
            cr = ONE;     cg = '0;      cb = ramp_dn;
         end
      endcase
   end

   // Above 1.0 the excess over one drives the blend toward white
   assign blend  = in_level > hitr_pkg::LVL_ONE;
   assign t_full = in_level - hitr_pkg::LVL_ONE;
   assign t      = t_full[hitr_pkg::T_W-1:0];
   assign mult_b = blend ? {1'b0, t} : in_level;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      v_in  = v_ff;
      nr_in = nr_ff;
      ng_in = ng_ff;
      nb_in = nb_ff;
      if (in_ready) begin
         v_in  = in_valid;
         nr_in = scale_chan(cr, blend, mult_b);
         ng_in = scale_chan(cg, blend, mult_b);
         nb_in = scale_chan(cb, blend, mult_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      nr_ff <= nr_in;
      ng_ff <= ng_in;
      nb_ff <= nb_in;
   end

   assign out_valid = v_ff;
   assign out_num_r = nr_ff;
   assign out_num_g = ng_ff;
   assign out_num_b = nb_ff;

   // A scaled channel never passes full scale, so no byte can overflow
   a_num_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff |-> (nr_ff <= FULL && ng_ff <= FULL && nb_ff <= FULL))
      else $error("scaled channel above full scale");

endmodule

### sv/hitr_output.sv
// hitr_output: last pipeline stage and output register; multiplies by 255
// and truncates to bytes. Depends on hitr_pkg.
module hitr_output #(
   parameter int HUE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [HUE_BITS+8:0]          in_num_r,
   input  logic [HUE_BITS+8:0]          in_num_g,
   input  logic [HUE_BITS+8:0]          in_num_b,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [hitr_pkg::BYTE_W-1:0]  out_red,
   output logic [hitr_pkg::BYTE_W-1:0]  out_green,
   output logic [hitr_pkg::BYTE_W-1:0]  out_blue,
   output logic [hitr_pkg::PACK_W-1:0]  out_packed
);
   localparam int NUM_W = HUE_BITS + 9;
   localparam int P_W   = NUM_W + 8;

   logic [P_W-1:0]              pr, pg, pb;
   logic                        v_ff, v_in;
   logic [hitr_pkg::BYTE_W-1:0] r_ff, r_in, g_ff, g_in, b_ff, b_in;

   // Times 255 as shift and subtract; the byte is the integer part
   assign pr = {in_num_r, 8'b0} - {8'b0, in_num_r};
   assign pg = {in_num_g, 8'b0} - {8'b0, in_num_g};
   assign pb = {in_num_b, 8'b0} - {8'b0, in_num_b};

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      v_in = v_ff;
      r_in = r_ff;
      g_in = g_ff;
      b_in = b_ff;
      if (in_ready) begin
         v_in = in_valid;
         r_in = pr[NUM_W+6:NUM_W-1];
         g_in = pg[NUM_W+6:NUM_W-1];
         b_in = pb[NUM_W+6:NUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      r_ff <= r_in;
      g_ff <= g_in;
      b_ff <= b_in;
   end

   assign out_valid  = v_ff;
   assign out_red    = r_ff;
   assign out_green  = g_ff;
   assign out_blue   = b_ff;
   assign out_packed = {b_ff, g_ff, r_ff};

   // A response beat appears only after the stage before offered one
   a_rise_src: assert property (@(posedge clock) disable iff (reset)
      $rose(v_ff) |-> $past(in_valid))
      else $error("response valid without a beat from the scale stage");

endmodule

### sv/hue_intensity_to_rgb_top.sv
// hue_intensity_to_rgb_top: three-stage hue and intensity to RGB pipeline.
// Depends on hitr_pkg, hitr_req_if, hitr_rsp_if and the three stage modules.
//
//   channel  | dir | payload                                  | handshake
//   ---------+-----+------------------------------------------+-------------
//   req_if   | in  | hue[HUE_BITS], intensity (signed Q2.8)   | valid/ready
//   rsp_if   | out | red, green, blue bytes, packed_color[24] | valid/ready
//
// One beat per cycle sustained while the response side is ready.
// Stages: sector split and clamp, ramp select with one multiplier per channel,
// then times 255 into the output register. Each stage holds its own valid
// bit and refills as it drains, so a stalled response backs up stage by stage
// and no beat is lost or repeated. Reset (synchronous) empties all stages.
module hue_intensity_to_rgb_top #(
   parameter int HUE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   hitr_req_if.sink     req_if,
   hitr_rsp_if.source   rsp_if
);
   logic                       s1_valid, s1_ready;
   hitr_pkg::sector_type       s1_sector;
   logic [HUE_BITS-1:0]        s1_offset;
   logic [hitr_pkg::LVL_W-1:0] s1_level;

   logic                       s2_valid, s2_ready;
   logic [HUE_BITS+8:0]        s2_num_r, s2_num_g, s2_num_b;

   // Split hue and clamp intensity
   hitr_sector #(.HUE_BITS(HUE_BITS)) u_sector (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_if.valid),
      .in_ready     (req_if.ready),
      .in_hue       (req_if.hue),
      .in_intensity (req_if.intensity),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_sector   (s1_sector),
      .out_offset   (s1_offset),
      .out_level    (s1_level)
   );

   // Scale or blend the channel ramps
   hitr_scale #(.HUE_BITS(HUE_BITS)) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid),
      .in_ready   (s1_ready),
      .in_sector  (s1_sector),
      .in_offset  (s1_offset),
      .in_level   (s1_level),
      .out_valid  (s2_valid),
      .out_ready  (s2_ready),
      .out_num_r  (s2_num_r),
      .out_num_g  (s2_num_g),
      .out_num_b  (s2_num_b)
   );

   // Bytes and output register
   hitr_output #(.HUE_BITS(HUE_BITS)) u_output (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_ready   (s2_ready),
      .in_num_r   (s2_num_r),
      .in_num_g   (s2_num_g),
      .in_num_b   (s2_num_b),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_red    (rsp_if.red),
      .out_green  (rsp_if.green),
      .out_blue   (rsp_if.blue),
      .out_packed (rsp_if.packed_color)
   );

   // Back-pressure reaches the request side only with every stage full
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready && s1_valid && s2_valid))
      else $error("request stalled while the pipeline has room");

endmodule
